[hw/rtl/tlwc_pkg.sv]
// Shared widths, register indexes, controller states and command/status types.
package tlwc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int TEMP_W     = 18;
  localparam int TIME_W     = 20;
  localparam int GAIN_W     = 19;
  localparam int CORR_W     = 27;
  localparam int DEN_W      = TIME_W + 1;
  localparam int PROD_W     = GAIN_W + TEMP_W + 1;
  localparam int MAG_W      = PROD_W - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TAU  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF  = 2'd2;

  localparam logic [TIME_W-1:0] TAU_RESET  = 20'd1500;

  localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TARE   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ALPHA_WAIT,
    S_FILT_MUL,
    S_FILT_ADD,
    S_CORR_MUL,
    S_CORR_START,
    S_CORR_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic seed;
    logic div_start;
    logic div_corr;
    logic alpha_load;
    logic filt_mul;
    logic filt_add;
    logic corr_mul;
    logic corr_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic req;
    logic div_done;
  } status_t;

endpackage

[hw/rtl/tlwc_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module tlwc_div #(
  parameter int DW = 38
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DW-1:0]               num,
  input  logic [tlwc_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [DW-1:0]               quo
);
  import tlwc_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DW-1:0]     numsh;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem, numsh[DW-1]};
  assign ge     = rem_sh >= {1'b0, dsr};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dsr   <= den;
      numsh <= num;
      quo   <= '0;
    end else if (busy) begin
      rem   <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      numsh <= {numsh[DW-2:0], 1'b0};
      quo   <= {quo[DW-2:0], ge};
    end
  end

endmodule

[hw/rtl/tlwc_dp.sv]
// Datapath: configuration registers, lag filter state, multiplies, divider, output register.
module tlwc_dp #(
  parameter int FRAC_BITS = tlwc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tlwc_pkg::cmd_t                        cmd,
  output tlwc_pkg::status_t                     status,
  input  logic                                  in_req,
  input  logic signed [tlwc_pkg::TEMP_W-1:0]    in_probe,
  input  logic [tlwc_pkg::TIME_W-1:0]           in_elapsed,
  input  logic                                  cfg_we,
  input  logic [tlwc_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [tlwc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic signed [tlwc_pkg::CORR_W-1:0]    out_corr,
  output logic signed [tlwc_pkg::TEMP_W-1:0]    out_eff
);
  import tlwc_pkg::*;

  localparam int AW    = FRAC_BITS + 1;
  localparam int NUM_W = TIME_W + FRAC_BITS;
  localparam int DW    = NUM_W;
  localparam int FP_W  = TEMP_W + AW + 2;

  // divide by 1000: drop the three low bits, then multiply by ceil(2^40 / 125);
  // the product magnitude stays below 2^36, so bits 35:3 carry all of it
  localparam int Y_W     = MAG_W - 4;
  localparam int M_W     = 34;
  localparam int H_W     = 17;
  localparam int Q_SHIFT = 40;
  localparam int ACC_W   = Q_SHIFT + CORR_W;
  localparam logic [M_W-1:0] RECIP_125 = 34'd8796093023;
  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;
  localparam logic [1:0] PH_HH = 2'd3;

  localparam logic [AW-1:0]     ALPHA_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CORR_W-1:0] LIM_POS   = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic [CORR_W-1:0] LIM_NEG   = {1'b1, {(CORR_W-1){1'b0}}};

  // configuration
  logic [TIME_W-1:0]        tau;
  logic signed [GAIN_W-1:0] gain;
  logic signed [TEMP_W-1:0] ref_temp;

  // filter state and captured request
  logic signed [TEMP_W-1:0] filt;
  logic                     primed;
  logic                     req;
  logic signed [TEMP_W-1:0] probe;
  logic [TIME_W-1:0]        dt;

  logic [AW-1:0]            alpha;
  logic signed [FP_W-1:0]   fprod;
  logic signed [PROD_W-1:0] cprod;
  logic signed [CORR_W-1:0] corr;

  logic signed [TEMP_W:0]   err;
  logic signed [TEMP_W:0]   dref;
  logic signed [AW:0]       alpha_s;
  logic signed [FP_W-1:0]   step;
  logic                     cneg;
  logic [PROD_W-1:0]        cabs;
  logic                     div_done;
  logic [DW-1:0]            div_num;
  logic [DEN_W-1:0]         div_den;
  logic [DW-1:0]            quo;

  // reciprocal multiply for the divide by 1000
  logic                     rec_start;
  logic                     rbusy;
  logic                     rdone;
  logic [1:0]               rphase;
  logic [Y_W-1:0]           ry;
  logic [ACC_W-1:0]         acc;
  logic [H_W-1:0]           op_y;
  logic [H_W-1:0]           op_m;
  logic [2*H_W-1:0]         pp;
  logic [ACC_W-1:0]         pp_sh;
  logic [CORR_W-1:0]        cquo;

  assign err     = {probe[TEMP_W-1], probe} - {filt[TEMP_W-1], filt};
  assign dref    = {filt[TEMP_W-1], filt} - {ref_temp[TEMP_W-1], ref_temp};
  assign alpha_s = $signed({1'b0, alpha});
  assign step    = fprod >>> FRAC_BITS;
  assign cneg    = cprod[PROD_W-1];
  assign cabs    = cneg ? PROD_W'(-cprod) : PROD_W'(cprod);

  assign div_num = {dt, {FRAC_BITS{1'b0}}};
  assign div_den = {1'b0, dt} + {1'b0, tau};

  tlwc_div #(
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start && !cmd.div_corr),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign rec_start = cmd.div_start && cmd.div_corr;
  assign pp        = op_y * op_m;
  assign cquo      = acc[Q_SHIFT+CORR_W-1:Q_SHIFT];

  // one 17 x 17 partial product per cycle, low halves first
  always_comb begin
    case (rphase)
      PH_LL: begin
        op_y = ry[H_W-1:0];
        op_m = RECIP_125[H_W-1:0];
      end
      PH_LH: begin
        op_y = ry[H_W-1:0];
        op_m = RECIP_125[M_W-1:H_W];
      end
      PH_HL: begin
        op_y = {1'b0, ry[Y_W-1:H_W]};
        op_m = RECIP_125[H_W-1:0];
      end
      default: begin
        op_y = {1'b0, ry[Y_W-1:H_W]};
        op_m = RECIP_125[M_W-1:H_W];
      end
    endcase
  end

  always_comb begin
    case (rphase)
      PH_LL:   pp_sh = ACC_W'(pp);
      PH_HH:   pp_sh = {pp[ACC_W-2*H_W-1:0], {(2*H_W){1'b0}}};
      default: pp_sh = ACC_W'({pp, {H_W{1'b0}}});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy  <= 1'b0;
      rdone  <= 1'b0;
      rphase <= PH_LL;
    end else begin
      rdone <= 1'b0;
      if (rec_start) begin
        rbusy  <= 1'b1;
        rphase <= PH_LL;
      end else if (rbusy) begin
        rphase <= rphase + 2'd1;
        if (rphase == PH_HH) begin
          rbusy <= 1'b0;
          rdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_start) begin
      ry  <= cabs[Y_W+2:3];
      acc <= '0;
    end else if (rbusy) begin
      acc <= acc + pp_sh;
    end
  end

  assign status.primed   = primed;
  assign status.req      = req;
  assign status.div_done = div_done || rdone;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau      <= TAU_RESET;
      gain     <= '0;
      ref_temp <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TAU:  tau      <= cfg_wdata[TIME_W-1:0];
        REG_GAIN: gain     <= cfg_wdata[GAIN_W-1:0];
        REG_REF:  ref_temp <= cfg_wdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt   <= '0;
      primed <= 1'b0;
    end else if (cmd.seed) begin
      filt   <= probe;
      primed <= 1'b1;
    end else if (cmd.filt_add) begin
      filt <= filt + step[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req   <= in_req;
      probe <= in_probe;
      dt    <= in_elapsed;
    end
    if (cmd.alpha_load) begin
      // a zero denominator leaves the quotient all ones, which clamps to one
      alpha <= (quo > DW'(ALPHA_ONE)) ? ALPHA_ONE : quo[AW-1:0];
    end
    if (cmd.filt_mul) begin
      fprod <= err * alpha_s;
    end
    if (cmd.corr_mul) begin
      cprod <= gain * dref;
    end
    if (cmd.corr_load) begin
      if (cneg) begin
        corr <= (cquo > LIM_NEG) ? CORR_MIN : -$signed(cquo);
      end else begin
        corr <= (cquo > LIM_POS) ? CORR_MAX : $signed(cquo);
      end
    end
    if (cmd.out_load) begin
      out_corr <= (req == REQ_TARE) ? '0 : corr;
      out_eff  <= filt;
    end
  end

endmodule

[hw/rtl/tlwc_ctrl.sv]
// Controller: sequences one request through seed, filter update and correction.
module tlwc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tlwc_pkg::status_t  status,
  output tlwc_pkg::cmd_t     cmd,
  output tlwc_pkg::state_t   state
);
  import tlwc_pkg::*;

  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.primed) begin
          cmd.seed   = 1'b1;
          state_next = (status.req == REQ_TARE) ? S_DONE : S_CORR_MUL;
        end else if (status.req == REQ_SAMPLE) begin
          cmd.div_start = 1'b1;
          state_next    = S_ALPHA_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ALPHA_WAIT: begin
        if (status.div_done) begin
          cmd.alpha_load = 1'b1;
          state_next     = S_FILT_MUL;
        end
      end
      S_FILT_MUL: begin
        cmd.filt_mul = 1'b1;
        state_next   = S_FILT_ADD;
      end
      S_FILT_ADD: begin
        cmd.filt_add = 1'b1;
        state_next   = S_CORR_MUL;
      end
      S_CORR_MUL: begin
        cmd.corr_mul = 1'b1;
        state_next   = S_CORR_START;
      end
      S_CORR_START: begin
        cmd.div_start = 1'b1;
        cmd.div_corr  = 1'b1;
        state_next    = S_CORR_WAIT;
      end
      S_CORR_WAIT: begin
        if (status.div_done) begin
          cmd.corr_load = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/thermal_lag_weight_compensation_top.sv]
// A primed sample runs the alpha divider (one bit per cycle, DW = 20+FRAC_BITS bits, 36
// at FRAC_BITS 16), then filter update, correction multiply and divide by 1000; a seeding
// sample skips divider and filter update, a tare the correction; all may wait for m_tready.
// One request at a time, the next taken the cycle after the result is loaded.
// A new request is taken while a finished result still waits in the output register.
// Reset (rst, synchronous): filter unprimed and zero, tau 1500, gain and reference zero.
module thermal_lag_weight_compensation_top #(
  parameter int FRAC_BITS = tlwc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tlwc_pkg::IN_DATA_W-1:0]      s_tdata,   // probe_temp_mdeg[17:0], sample_gap_s[37:18]
  input  logic [0:0]                          s_tuser,   // req_type[0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tlwc_pkg::OUT_DATA_W-1:0]     m_tdata,   // correction_mg[26:0], effective_temp_mdeg[44:27]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlwc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tlwc_pkg::*;

  cmd_t                     cmd;
  status_t                  status;
  state_t                   state;
  logic signed [CORR_W-1:0] out_corr;
  logic signed [TEMP_W-1:0] out_eff;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(OUT_DATA_W-CORR_W-TEMP_W){1'b0}}, out_eff, out_corr};

  tlwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  tlwc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_req     (s_tuser[0]),
    .in_probe   (s_tdata[TEMP_W-1:0]),
    .in_elapsed (s_tdata[TEMP_W+TIME_W-1:TEMP_W]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_corr   (out_corr),
    .out_eff    (out_eff)
  );

  // an accepted request closes the input until it has been worked off
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while the previous one is still in progress");

  // the divider only finishes while the controller waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_ALPHA_WAIT || state == S_CORR_WAIT))
    else $error("divider result arrived outside a wait state");

  // the block is ready for a request straight after reset
  a_ready_after_rst: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

[tb/thermal_lag_weight_compensation_top_test.sv]
// Self-checking testbench for the thermal lag weight compensation block.
module thermal_lag_weight_compensation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tlwc_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam longint ONE_Q   = longint'(1) << FRAC;
  localparam int SETTLE_CYC  = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYC    = 600;
  localparam int HOLD_AT     = 1450;
  localparam int RAND_PHASES = 11;
  localparam int PHASE_REQS  = 150;

  typedef struct {
    logic                     req;
    logic signed [TEMP_W-1:0] probe;
    logic [TIME_W-1:0]        dt;
  } probe_req_t;

  typedef struct {
    logic signed [CORR_W-1:0] corr;
    logic signed [TEMP_W-1:0] eff;
  } comp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  thermal_lag_weight_compensation_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Own copy of the block's registers and filter state
  logic [TIME_W-1:0]        tau_q    = TAU_RESET;
  logic signed [GAIN_W-1:0] gain_q   = '0;
  logic signed [TEMP_W-1:0] ref_q    = '0;
  logic signed [TEMP_W-1:0] filt_q   = '0;
  logic                     primed_q = 1'b0;
  logic signed [TEMP_W-1:0] last_tare_q = '0;
  bit                       tare_seen = 1'b0;

  probe_req_t   probe_req_q[$];
  comp_result_t compensation_q[$];
  probe_req_t   in_flight;

  int req_queued = 0;
  int req_accepted = 0;
  int results_seen = 0;
  int errors = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 78;
  int hold_left = 0;
  bit held = 1'b0;
  int quiet_cycles = 0;

  logic signed [CORR_W-1:0] got_corr;
  logic signed [TEMP_W-1:0] got_eff;
  comp_result_t             want;

  function automatic void predict_compensation(input probe_req_t it);
    longint den, alpha, err, diff, corr;
    comp_result_t r;
    if (!primed_q) begin
      filt_q   = it.probe;
      primed_q = 1'b1;
    end else if (it.req == REQ_SAMPLE) begin
      den = longint'(it.dt) + longint'(tau_q);
      if (den == 0) begin
        alpha = ONE_Q;
      end else begin
        alpha = (longint'(it.dt) <<< FRAC) / den;
        if (alpha > ONE_Q) alpha = ONE_Q;
      end
      err    = longint'(it.probe) - longint'(filt_q);
      filt_q = TEMP_W'(longint'(filt_q) + ((err * alpha) >>> FRAC));
    end
    corr = 0;
    if (it.req == REQ_SAMPLE) begin
      diff = longint'(filt_q) - longint'(ref_q);
      corr = (longint'(gain_q) * diff) / 1000;
      if (corr > longint'(CORR_MAX)) corr = longint'(CORR_MAX);
      if (corr < longint'(CORR_MIN)) corr = longint'(CORR_MIN);
    end else begin
      last_tare_q = filt_q;
      tare_seen   = 1'b1;
    end
    r.corr = CORR_W'(corr);
    r.eff  = filt_q;
    compensation_q.push_back(r);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_compensation(in_flight);
        req_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (probe_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = probe_req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, in_flight.dt, in_flight.probe};
          s_tuser  <= in_flight.req;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_corr = m_tdata[CORR_W-1:0];
        got_eff  = m_tdata[CORR_W+TEMP_W-1:CORR_W];
        results_seen++;
        if (compensation_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: corr %0d eff %0d", got_corr, got_eff);
          errors++;
        end else begin
          want = compensation_q.pop_front();
          if (got_corr !== want.corr || got_eff !== want.eff) begin
            if (errors < 10)
              $display("result %0d: corr exp %0d got %0d, eff exp %0d got %0d",
                       results_seen, want.corr, got_corr, want.eff, got_eff);
            errors++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYC;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[thermal_lag_weight_compensation_top] ERROR");
      $finish;
    end
  end

  task automatic push_req(input logic req, input int probe, input int dt);
    probe_req_t it;
    it.req   = req;
    it.probe = TEMP_W'(probe);
    it.dt    = TIME_W'(dt);
    probe_req_q.push_back(it);
    req_queued++;
  endtask

  // Wait until every request has its result, then let the block settle
  task automatic drain();
    while (!(req_accepted == req_queued && compensation_q.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TAU:  tau_q  = TIME_W'(data);
      REG_GAIN: gain_q = GAIN_W'(data);
      REG_REF:  ref_q  = TEMP_W'(data);
      default: ;
    endcase
  endtask

  initial begin
    int tau, gain, refv, walk, r, probe, dt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset settings: seeding sample ignores its elapsed time, zero gain
    push_req(REQ_SAMPLE, 25000, 1048575);
    push_req(REQ_SAMPLE, 125000, 60);
    push_req(REQ_TARE, -55000, 5);
    drain();

    // Zero tau: a zero denominator passes the probe straight through
    write_reg(REG_TAU, 0);
    write_reg(REG_GAIN, 200000);
    write_reg(REG_REF, -55000);
    push_req(REQ_SAMPLE, 125000, 0);
    push_req(REQ_SAMPLE, -55000, 0);
    push_req(REQ_SAMPLE, -55000, 1048575);
    drain();

    write_reg(REG_TAU, 1048575);
    write_reg(REG_GAIN, -200000);
    write_reg(REG_REF, 125000);
    push_req(REQ_SAMPLE, 125000, 1);
    push_req(REQ_SAMPLE, 125000, 1048575);
    push_req(REQ_SAMPLE, -55000, 0);
    push_req(REQ_TARE, 0, 0);
    drain();

    // Full-width gain and reference drive the correction into saturation
    write_reg(REG_TAU, 0);
    write_reg(REG_GAIN, -262144);
    write_reg(REG_REF, -131072);
    push_req(REQ_SAMPLE, 131071, 0);
    push_req(REQ_SAMPLE, -131072, 0);
    drain();
    write_reg(REG_GAIN, 262143);
    push_req(REQ_SAMPLE, 131071, 0);
    push_req(REQ_TARE, -131072, 9);
    drain();
    write_reg(REG_REF, last_tare_q);
    push_req(REQ_SAMPLE, 131071, 3);
    push_req(REQ_SAMPLE, -131072, 0);
    drain();

    // Truncation toward zero, then a half step either way with tau 1500
    write_reg(REG_GAIN, 1);
    write_reg(REG_REF, 0);
    push_req(REQ_SAMPLE, -1999, 0);
    push_req(REQ_SAMPLE, 1999, 0);
    drain();
    write_reg(REG_TAU, 1500);
    push_req(REQ_SAMPLE, 125000, 1500);
    push_req(REQ_SAMPLE, -55000, 1500);
    push_req(REQ_SAMPLE, 0, 1);
    drain();

    walk = 22000;
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 24;
        recv_idle_pct = 78;
      end else if (p < 8) begin
        send_idle_pct = 78;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p % 6)
        0: tau = 1500;
        1: tau = 0;
        2: tau = 1048575;
        3: tau = $urandom_range(5000, 1);
        4: tau = $urandom();
        default: tau = $urandom_range(120, 1);
      endcase
      case (p % 5)
        0: gain = int'($urandom_range(400000)) - 200000;
        1: gain = 200000;
        2: gain = -200000;
        3: gain = $urandom();
        default: gain = $urandom_range(50, 1);
      endcase
      if (tare_seen && $urandom_range(1) == 1) begin
        refv = last_tare_q;
      end else begin
        case (p % 3)
          0: refv = -55000;
          1: refv = 125000;
          default: refv = int'($urandom_range(180000)) - 55000;
        endcase
      end
      write_reg(REG_TAU, tau);
      write_reg(REG_GAIN, gain);
      write_reg(REG_REF, refv);

      for (int n = 0; n < PHASE_REQS; n++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          push_req(REQ_TARE, $urandom(), $urandom());
        end else if (r < 20) begin
          push_req(REQ_SAMPLE, $urandom(), $urandom());
        end else if (r < 25) begin
          push_req(REQ_SAMPLE, int'($urandom_range(180000)) - 55000, 0);
        end else begin
          // Slowly drifting room temperature sampled every few minutes
          walk = walk + int'($urandom_range(4000)) - 2000;
          if (walk > 125000) walk = 125000;
          if (walk < -55000) walk = -55000;
          probe = walk;
          dt = $urandom_range(900, 1);
          push_req(REQ_SAMPLE, probe, dt);
        end
      end
      drain();
    end

    if (errors == 0 && compensation_q.size() == 0) begin
      $display("[thermal_lag_weight_compensation_top] OK");
    end else begin
      $display("[thermal_lag_weight_compensation_top] ERROR");
    end
    $finish;
  end

endmodule
